[sv/vpdi_pkg.sv]
// ----------------------------------------------------------------------------
// vpdi_pkg
// Shared types, constants and the vertex packing function of the vertex
// dedup indexer.
// ----------------------------------------------------------------------------
package vpdi_pkg;

   // store geometry
   localparam int VERTEX_CAPACITY = 16384;
   localparam int ADDR_W          = $clog2(VERTEX_CAPACITY);
   localparam int COUNT_W         = $clog2(VERTEX_CAPACITY + 1);
   localparam int INDEX_W         = 16;
   localparam int WORD_W          = 32;
   localparam int KEY_LSB         = 5;
   localparam int KEY_W           = WORD_W - KEY_LSB;

   // input field widths
   localparam int POS_W = 5;
   localparam int TEX_W = 4;

   // opcodes
   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMPARE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch_req;
      logic clear_store;
      logic scan_next;
      logic rsp_hit;
      logic rsp_miss;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_end;
      logic match;
   } dp_status_type;

   // pack one vertex: x 31..27, y 26..22, z 21..17, u 16..13, v 12..9, light 8..5
   function automatic logic [WORD_W-1:0] pack_word(
      input logic [POS_W-1:0] x,
      input logic [POS_W-1:0] y,
      input logic [POS_W-1:0] z,
      input logic [TEX_W-1:0] u,
      input logic [TEX_W-1:0] v,
      input logic [TEX_W-1:0] light
   );
      return {x, y, z, u, v, light, {KEY_LSB{1'b0}}};
   endfunction

endpackage

[sv/vertex_pack_dedup_indexer_unit.sv]
// ----------------------------------------------------------------------------
// vertex_pack_dedup_indexer_unit
// Packs a vertex into a 32-bit word and returns the index of its first equal
// entry in the unique vertex store, appending it on a miss while there is room.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start & !busy        req_opcode, req_pos_*, req_tex_*, req_light_level
//  response  rsp_strobe (1 cyc)   rsp_vertex_index, rsp_is_new, rsp_packed_word,
//                                 rsp_overflow
//
//  A clear never raises busy; its result strobes the next cycle.
//  An add scans the store one entry at a time, reading it in ST_LOOKUP and
//  comparing it in ST_COMPARE, until a hit or the end of the stored entries;
//  the result strobes in the first cycle with busy low.
//  Synchronous reset empties the store count; store contents need no clear.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module vertex_pack_dedup_indexer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [vpdi_pkg::POS_W-1:0]   req_pos_x,
   input  logic [vpdi_pkg::POS_W-1:0]   req_pos_y,
   input  logic [vpdi_pkg::POS_W-1:0]   req_pos_z,
   input  logic [vpdi_pkg::TEX_W-1:0]   req_tex_u,
   input  logic [vpdi_pkg::TEX_W-1:0]   req_tex_v,
   input  logic [vpdi_pkg::TEX_W-1:0]   req_light_level,
   output logic                         rsp_strobe,
   output logic [vpdi_pkg::INDEX_W-1:0] rsp_vertex_index,
   output logic                         rsp_is_new,
   output logic [vpdi_pkg::WORD_W-1:0]  rsp_packed_word,
   output logic                         rsp_overflow
);
   import vpdi_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequence the search
   vpdi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // store, compare and result registers
   vpdi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_tex_u        (req_tex_u),
      .req_tex_v        (req_tex_v),
      .req_light_level  (req_light_level),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_packed_word  (rsp_packed_word),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

[sv/vpdi_ram.sv]
// ----------------------------------------------------------------------------
// vpdi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/vpdi_ctrl.sv]
// ----------------------------------------------------------------------------
// vpdi_ctrl
// Controller of the vertex dedup indexer: sequences the linear store search.
// ----------------------------------------------------------------------------
module vpdi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_opcode,
   input  vpdi_pkg::dp_status_type status,
   output vpdi_pkg::ctl_cmd_type   cmd,
   output logic                   busy
);
   import vpdi_pkg::*;

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (opcode_type'(req_opcode) == OP_CLEAR) begin
                  cmd.clear_store = 1'b1;
               end else begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (status.scan_end) begin
               cmd.rsp_miss = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.match) begin
               cmd.rsp_hit = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[sv/vpdi_datapath.sv]
// ----------------------------------------------------------------------------
// vpdi_datapath
// Datapath of the vertex dedup indexer: key register, scan pointer, store
// count, vertex store and result registers.
// ----------------------------------------------------------------------------
module vpdi_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  vpdi_pkg::ctl_cmd_type              cmd,
   input  logic [vpdi_pkg::POS_W-1:0]         req_pos_x,
   input  logic [vpdi_pkg::POS_W-1:0]         req_pos_y,
   input  logic [vpdi_pkg::POS_W-1:0]         req_pos_z,
   input  logic [vpdi_pkg::TEX_W-1:0]         req_tex_u,
   input  logic [vpdi_pkg::TEX_W-1:0]         req_tex_v,
   input  logic [vpdi_pkg::TEX_W-1:0]         req_light_level,
   output vpdi_pkg::dp_status_type            status,
   output logic                               rsp_strobe,
   output logic [vpdi_pkg::INDEX_W-1:0]       rsp_vertex_index,
   output logic                               rsp_is_new,
   output logic [vpdi_pkg::WORD_W-1:0]        rsp_packed_word,
   output logic                               rsp_overflow
);
   import vpdi_pkg::*;

   logic [WORD_W-1:0]  word_ff;
   logic [COUNT_W-1:0] scan_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [KEY_W-1:0]   key;
   logic [KEY_W-1:0]   rd_data;
   logic               full;
   logic               wr_en;

   logic               strobe_ff;
   logic [INDEX_W-1:0] index_ff;
   logic               is_new_ff;
   logic [WORD_W-1:0]  out_word_ff;
   logic               overflow_ff;

   assign key  = word_ff[WORD_W-1:KEY_LSB];
   assign full = (count_ff == COUNT_W'(VERTEX_CAPACITY));

   // status to controller
   assign status.scan_end = (scan_ff == count_ff);
   assign status.match    = (rd_data == key);

   // append on a miss while there is room
   assign wr_en = cmd.rsp_miss && !full;

   // latch the packed word and advance the scan pointer
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         word_ff <= pack_word(req_pos_x, req_pos_y, req_pos_z,
                              req_tex_u, req_tex_v, req_light_level);
         scan_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_ff <= scan_ff + COUNT_W'(1);
      end
   end

   // update the store count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear_store) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // vertex store
   vpdi_ram #(
      .WIDTH (KEY_W),
      .DEPTH (VERTEX_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (key),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // strobe one result word
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.clear_store || cmd.rsp_hit || cmd.rsp_miss;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.clear_store) begin
         index_ff    <= '0;
         is_new_ff   <= 1'b0;
         out_word_ff <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.rsp_hit) begin
         index_ff    <= INDEX_W'(scan_ff);
         is_new_ff   <= 1'b0;
         out_word_ff <= word_ff;
         overflow_ff <= 1'b0;
      end else if (cmd.rsp_miss) begin
         index_ff    <= full ? '0 : INDEX_W'(count_ff);
         is_new_ff   <= !full;
         out_word_ff <= word_ff;
         overflow_ff <= full;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_is_new       = is_new_ff;
   assign rsp_packed_word  = out_word_ff;
   assign rsp_overflow     = overflow_ff;

endmodule
